/* design/small_matrix_inverse_defines.svh */
`ifndef SMALL_MATRIX_INVERSE_DEFINES_SVH
`define SMALL_MATRIX_INVERSE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SMI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define SMI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/smi_pkg.sv */
package smi_pkg;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SINGULAR = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  localparam logic [1:0] SIZE_TWO   = 2'd2;
  localparam logic [1:0] SIZE_RESET = 2'd3;

  // per cofactor: first product pair, second product pair (row-major element index)
  localparam int MINOR_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{1, 8, 2, 7}, '{1, 5, 2, 4},
    '{3, 8, 5, 6}, '{0, 8, 2, 6}, '{0, 5, 2, 3},
    '{3, 7, 4, 6}, '{0, 7, 1, 6}, '{0, 4, 1, 3}
  };

  // cofactors that take a minus sign
  localparam logic [8:0] MINOR_NEG = 9'b010101010;

  typedef struct packed {
    logic singular;
    logic det_sat;
  } det_flags_t;

endpackage

/* design/smi_front.sv */
module smi_front #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic                              two_i,
  input  logic signed [ELEMENT_WIDTH-1:0]   a_i [9],
  output logic                              v_o,
  output logic [2*ELEMENT_WIDTH:0]          amag_o [9],
  output logic [8:0]                        aneg_o,
  output logic [3*ELEMENT_WIDTH+2:0]        dmag_o,
  output logic                              dneg_o,
  output logic [ELEMENT_WIDTH-1:0]          det_o,
  output smi_pkg::det_flags_t               flags_o
);

  localparam int W  = ELEMENT_WIDTH;
  localparam int AW = 2*ELEMENT_WIDTH + 1;
  localparam int DW = 3*ELEMENT_WIDTH + 3;

  // stage 1: input register
  logic                 v1_r, two1_r;
  logic signed [W-1:0]  a1_r [9];

  // stage 2: minor products
  logic                 v2_r, two2_r;
  logic signed [2*W-1:0] pa2_r [9];
  logic signed [2*W-1:0] pb2_r [9];
  logic signed [W-1:0]  c2_r [5];

  // stage 3: cofactors
  logic                 v3_r, two3_r;
  logic signed [AW-1:0] mnr [9];
  logic signed [AW-1:0] adjsel [9];
  logic signed [AW-1:0] adjo3_r [9];
  logic signed [AW-1:0] cof3_r [3];
  logic signed [AW-1:0] det23_r;
  logic signed [W-1:0]  c3_r [3];

  // stage 4: split determinant products
  logic                 v4_r, two4_r;
  logic signed [2*W:0]  pl4_r [3];
  logic signed [2*W:0]  ph4_r [3];
  logic signed [AW-1:0] adjo4_r [9];
  logic signed [AW-1:0] det24_r;

  // stage 5: recombined terms
  logic                 v5_r, two5_r;
  logic signed [DW-1:0] t5_r [3];
  logic signed [AW-1:0] adjo5_r [9];
  logic signed [AW-1:0] det25_r;

  // stage 6: determinant
  logic                 v6_r, two6_r;
  logic signed [DW-1:0] det6_r;
  logic signed [AW-1:0] adjo6_r [9];

  // stage 7: magnitudes and determinant output
  logic                 v7_r, dneg7_r;
  logic [AW-1:0]        amag7_r [9];
  logic [8:0]           aneg7_r;
  logic [DW-1:0]        dmag7_r;
  logic [W-1:0]         det7_r;
  smi_pkg::det_flags_t  flags7_r;

  logic                 dneg;
  logic [DW-1:0]        dmag, dsh, lim;
  logic [W-1:0]         detv;
  logic                 dsat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= a_i;
      two1_r <= two_i;
      two2_r <= two1_r;
      for (int i = 0; i < 5; i++) begin
        c2_r[i] <= a1_r[i];
      end
      two3_r  <= two2_r;
      adjo3_r <= adjsel;
      cof3_r[0] <= mnr[0];
      cof3_r[1] <= mnr[3];
      cof3_r[2] <= mnr[6];
      det23_r <= mnr[8];
      for (int i = 0; i < 3; i++) begin
        c3_r[i] <= c2_r[i];
      end
      two4_r  <= two3_r;
      adjo4_r <= adjo3_r;
      det24_r <= det23_r;
      two5_r  <= two4_r;
      adjo5_r <= adjo4_r;
      det25_r <= det24_r;
      for (int i = 0; i < 3; i++) begin
        t5_r[i] <= (DW'(ph4_r[i]) <<< W) + DW'(pl4_r[i]);
      end
      two6_r  <= two5_r;
      adjo6_r <= adjo5_r;
      det6_r  <= two5_r ? DW'(det25_r) : t5_r[0] + t5_r[1] + t5_r[2];
    end
  end

  genvar k;
  generate
    for (k = 0; k < 9; k++) begin : g_minor
      always_ff @(posedge clk) begin
        if (en) begin
          pa2_r[k] <= a1_r[smi_pkg::MINOR_IDX[k][0]] * a1_r[smi_pkg::MINOR_IDX[k][1]];
          pb2_r[k] <= a1_r[smi_pkg::MINOR_IDX[k][2]] * a1_r[smi_pkg::MINOR_IDX[k][3]];
        end
      end
      if (smi_pkg::MINOR_NEG[k]) begin : g_neg
        assign mnr[k] = AW'(pb2_r[k]) - AW'(pa2_r[k]);
      end else begin : g_pos
        assign mnr[k] = AW'(pa2_r[k]) - AW'(pb2_r[k]);
      end
    end
    for (k = 0; k < 3; k++) begin : g_detmul
      always_ff @(posedge clk) begin
        if (en) begin
          pl4_r[k] <= c3_r[k] * $signed({1'b0, cof3_r[k][W-1:0]});
          ph4_r[k] <= c3_r[k] * $signed(cof3_r[k][AW-1:W]);
        end
      end
    end
  endgenerate

  // order two uses the plain 2x2 adjugate
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      adjsel[i] = two2_r ? '0 : mnr[i];
    end
    if (two2_r) begin
      adjsel[0] = AW'(c2_r[4]);
      adjsel[1] = -AW'(c2_r[1]);
      adjsel[3] = -AW'(c2_r[3]);
      adjsel[4] = AW'(c2_r[0]);
    end
  end

  always_comb begin
    dneg = det6_r[DW-1];
    dmag = dneg ? DW'(-det6_r) : DW'(det6_r);
    dsh  = two6_r ? (dmag >> FRACTION_BITS) : (dmag >> (2*FRACTION_BITS));
    lim  = DW'(1) << (W-1);
    dsat = 1'b0;
    if (!dneg && dsh >= lim) begin
      detv = {1'b0, {(W-1){1'b1}}};
      dsat = 1'b1;
    end else if (dneg && dsh > lim) begin
      detv = {1'b1, {(W-1){1'b0}}};
      dsat = 1'b1;
    end else begin
      detv = dneg ? -dsh[W-1:0] : dsh[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        aneg7_r[i] <= adjo6_r[i][AW-1];
        amag7_r[i] <= adjo6_r[i][AW-1] ? AW'(-adjo6_r[i]) : AW'(adjo6_r[i]);
      end
      dmag7_r           <= dmag;
      dneg7_r           <= dneg;
      det7_r            <= detv;
      flags7_r.singular <= (det6_r == '0);
      flags7_r.det_sat  <= dsat;
    end
  end

  assign v_o     = v7_r;
  assign amag_o  = amag7_r;
  assign aneg_o  = aneg7_r;
  assign dmag_o  = dmag7_r;
  assign dneg_o  = dneg7_r;
  assign det_o   = det7_r;
  assign flags_o = flags7_r;

endmodule

/* design/smi_div.sv */
module smi_div #(
  parameter int NW  = 129,
  parameter int DW  = 99,
  parameter int QW  = 32,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_i,
  input  logic [NW-1:0]  n_i,
  input  logic [DW-1:0]  d_i,
  input  logic [SBW-1:0] sb_i,
  output logic           v_o,
  output logic [QW-1:0]  q_o,
  output logic           ovf_o,
  output logic [SBW-1:0] sb_o
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0]  rem_r [QW];
  logic [DW-1:0]  d_r   [QW];
  logic [QW-1:0]  q_r   [QW+1];
  logic           ovf_r [QW+1];
  logic           v_r   [QW+1];
  logic [SBW-1:0] sb_r  [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= CW'(n_i);
      d_r[0]   <= d_i;
      q_r[0]   <= '0;
      ovf_r[0] <= CW'(n_i) >= (CW'(d_i) << QW);
      sb_r[0]  <= sb_i;
    end
  end

  genvar s;
  generate
    for (s = 0; s <= QW; s++) begin : g_valid
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (en) begin
          v_r[s] <= (s == 0) ? v_i : v_r[(s == 0) ? 0 : s-1];
        end
      end
    end
    for (s = 1; s <= QW; s++) begin : g_step
      logic [CW-1:0] dd;
      logic          ge;
      assign dd = CW'(d_r[s-1]) << (QW - s);
      assign ge = rem_r[s-1] >= dd;
      always_ff @(posedge clk) begin
        if (en) begin
          q_r[s]   <= q_r[s-1] | (QW'(ge) << (QW - s));
          ovf_r[s] <= ovf_r[s-1];
          sb_r[s]  <= sb_r[s-1];
        end
      end
      if (s < QW) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[s] <= ge ? rem_r[s-1] - dd : rem_r[s-1];
            d_r[s]   <= d_r[s-1];
          end
        end
      end
    end
  endgenerate

  assign v_o   = v_r[QW];
  assign q_o   = q_r[QW];
  assign ovf_o = ovf_r[QW];
  assign sb_o  = sb_r[QW];

endmodule

/* design/small_matrix_inverse.sv */
// channel | direction | contents
// in_     | request in  | nine matrix elements, row-major
// out_    | request out | nine inverse elements and determinant, status in tuser
// cfg_    | write in    | matrix order (2 or 3), always ready
//
// one matrix accepted per cycle while in_tready is high, results in order
// pipeline: 7 adjugate and determinant stages,
// ELEMENT_WIDTH + 1 stages of the pipelined restoring divider, one output register
// synchronous active-low reset clears valid bits and sets order 3
// a two-entry output buffer absorbs a stall; in_tready drops only while it is full
`include "small_matrix_inverse_defines.svh"

module small_matrix_inverse #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // a00, a01, a02, a10, a11, a12, a20, a21, a22
  input  logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0]          in_tdata,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, determinant
  output logic [((10*ELEMENT_WIDTH+7)/8)*8-1:0]         out_tdata,
  // status
  output logic [1:0]                                    out_tuser,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [1:0]                                    cfg_data
);

  localparam int W   = ELEMENT_WIDTH;
  localparam int AW  = 2*ELEMENT_WIDTH + 1;
  localparam int DW  = 3*ELEMENT_WIDTH + 3;
  localparam int NW  = AW + 2*FRACTION_BITS;
  localparam int OTW = ((10*ELEMENT_WIDTH+7)/8)*8;
  localparam int SB0 = W + 3;

  logic [1:0]          size_r;
  logic                en;
  logic signed [W-1:0] a_in [9];

  logic                fv;
  logic [AW-1:0]       amag [9];
  logic [8:0]          aneg;
  logic [DW-1:0]       dmag;
  logic                dneg;
  logic [W-1:0]        detf;
  smi_pkg::det_flags_t flagsf;

  logic [W-1:0]        q   [9];
  logic [8:0]          ovf;
  logic [8:0]          qneg;
  logic [8:0]          qv;
  logic [SB0-1:0]      sb0;

  logic [W:0]          res [9];
  logic [W-1:0]        det_q;
  smi_pkg::det_flags_t flags_q;
  logic [OTW-1:0]      data_nxt;
  logic [1:0]          user_nxt;
  logic                any_sat;
  logic                push;

  logic                out_valid_r, skid_v_r;
  logic [OTW-1:0]      out_data_r, skid_data_r;
  logic [1:0]          out_user_r, skid_user_r;

  function automatic logic [W:0] sat_out(input logic [W-1:0] qq, input logic ov,
                                         input logic ng);
    logic [W-1:0] lim;
    logic [W:0]   r;
    lim = {1'b1, {(W-1){1'b0}}};
    if (!ng && (ov || qq >= lim)) begin
      r = {1'b1, ~lim};
    end else if (ng && (ov || qq > lim)) begin
      r = {1'b1, lim};
    end else begin
      r = {1'b0, ng ? -qq : qq};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= smi_pkg::SIZE_RESET;
    end else if (cfg_valid) begin
      size_r <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  assign en        = !skid_v_r;
  assign in_tready = !skid_v_r;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      a_in[i] = in_tdata[i*W +: W];
    end
  end

  smi_front #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .two_i    (size_r == smi_pkg::SIZE_TWO),
    .a_i      (a_in),
    .v_o      (fv),
    .amag_o   (amag),
    .aneg_o   (aneg),
    .dmag_o   (dmag),
    .dneg_o   (dneg),
    .det_o    (detf),
    .flags_o  (flagsf)
  );

  genvar k;
  generate
    for (k = 0; k < 9; k++) begin : g_lane
      if (k == 0) begin : g_first
        smi_div #(.NW(NW), .DW(DW), .QW(W), .SBW(SB0)) u_div (
          .clk   (clk),
          .rst_n (rst_n),
          .en    (en),
          .v_i   (fv),
          .n_i   (NW'(amag[k]) << (2*FRACTION_BITS)),
          .d_i   (dmag),
          .sb_i  ({detf, flagsf, aneg[k] ^ dneg}),
          .v_o   (qv[k]),
          .q_o   (q[k]),
          .ovf_o (ovf[k]),
          .sb_o  (sb0)
        );
        assign qneg[k] = sb0[0];
      end else begin : g_rest
        smi_div #(.NW(NW), .DW(DW), .QW(W), .SBW(1)) u_div (
          .clk   (clk),
          .rst_n (rst_n),
          .en    (en),
          .v_i   (fv),
          .n_i   (NW'(amag[k]) << (2*FRACTION_BITS)),
          .d_i   (dmag),
          .sb_i  (aneg[k] ^ dneg),
          .v_o   (qv[k]),
          .q_o   (q[k]),
          .ovf_o (ovf[k]),
          .sb_o  (qneg[k])
        );
      end
    end
  endgenerate

  assign det_q   = sb0[SB0-1:3];
  assign flags_q = smi_pkg::det_flags_t'(sb0[2:1]);

  always_comb begin
    data_nxt = '0;
    any_sat  = flags_q.det_sat;
    for (int i = 0; i < 9; i++) begin
      res[i]              = sat_out(q[i], ovf[i], qneg[i]);
      any_sat             = any_sat | res[i][W];
      data_nxt[i*W +: W]  = res[i][W-1:0];
    end
    data_nxt[9*W +: W] = det_q;
    if (flags_q.singular) begin
      data_nxt = '0;
      user_nxt = smi_pkg::STATUS_SINGULAR;
    end else if (any_sat) begin
      user_nxt = smi_pkg::STATUS_SAT;
    end else begin
      user_nxt = smi_pkg::STATUS_OK;
    end
  end

  // all lanes advance together, so any lane's valid stands for the item
  assign push = en && qv[0] && (qv[8:1] == 8'hff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= skid_v_r || push;
      skid_v_r    <= 1'b0;
    end else if (push) begin
      skid_v_r    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_v_r ? skid_data_r : data_nxt;
      out_user_r <= skid_v_r ? skid_user_r : user_nxt;
    end else if (push) begin
      skid_data_r <= data_nxt;
      skid_user_r <= user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `SMI_ASSERT_SAME(a_skid_needs_out, skid_v_r, out_tvalid)
  `SMI_ASSERT_SAME(a_singular_zero, out_tvalid && out_tuser == smi_pkg::STATUS_SINGULAR, out_tdata == '0)
  `SMI_ASSERT_NEXT(a_skid_holds, skid_v_r && !out_tready, skid_v_r && out_tvalid)

endmodule
